// File: hw/rtl/vmdiv_pkg.sv
// Package: opcodes, payload types and pipeline constants for the VM integer ALU.
`timescale 1ns / 1ps
package vmdiv_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned BitsPerStage = 4;
  localparam int unsigned DivStages = DataW / BitsPerStage;

  typedef enum logic [2:0] {
    OP_DIV  = 3'd0,
    OP_MOD  = 3'd1,
    OP_SHL  = 3'd2,
    OP_SHRL = 3'd3,
    OP_SHRA = 3'd4,
    OP_SEXS = 3'd5,
    OP_SEXB = 3'd6,
    OP_NONE = 3'd7
  } op_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
  } req_t;

  typedef struct packed {
    logic [31:0] result;
    logic        divide_error;
  } rsp_t;

  // State carried through the divider stages.
  typedef struct packed {
    logic        is_div;
    logic        is_mod;
    logic        neg_q;
    logic        neg_r;
    logic        dz;
    logic [31:0] quo;
    logic [31:0] rem;
    logic [31:0] dvs;
    logic [31:0] other;
  } dstate_t;
endpackage

// File: hw/rtl/vmdiv_if.sv
// Valid/ready channel interface carrying one payload.
`timescale 1ns / 1ps
interface vmdiv_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/vmdiv_front.sv
// Entry stage: operand magnitudes, shift and sign-extension results.
`timescale 1ns / 1ps
module vmdiv_front (
  input  vmdiv_pkg::req_t    req,
  output vmdiv_pkg::dstate_t st
);
  import vmdiv_pkg::*;
  logic [31:0] a, b, ma, mb, short_res;
  logic        bad;
  op_t         op;

  always_comb begin
    a  = req.operand_a;
    b  = req.operand_b;
    op = op_t'(req.mode);
    ma = a[31] ? 32'(-a) : a;
    mb = b[31] ? 32'(-b) : b;
    bad = b[31] || (b[30:5] != '0);
    unique case (op)
      OP_SHL:  short_res = bad ? '0 : (a << b[4:0]);
      OP_SHRL: short_res = bad ? '0 : (a >> b[4:0]);
      OP_SHRA: short_res = bad ? {32{a[31]}} : 32'($signed(a) >>> b[4:0]);
      OP_SEXS: short_res = {{16{a[15]}}, a[15:0]};
      OP_SEXB: short_res = {{24{a[7]}}, a[7:0]};
      default: short_res = '0;
    endcase
    st.is_div = (op == OP_DIV) || (op == OP_MOD);
    st.is_mod = (op == OP_MOD);
    st.neg_q  = (op == OP_DIV) && (a[31] ^ b[31]);
    st.neg_r  = (op == OP_MOD) && a[31];
    st.dz     = st.is_div && (b == '0);
    st.quo    = ma;
    st.rem    = '0;
    st.dvs    = mb;
    st.other  = short_res;
  end
endmodule

// File: hw/rtl/vmdiv_div_step.sv
// One divider stage: restoring division over BitsPerStage quotient bits.
`timescale 1ns / 1ps
module vmdiv_div_step (
  input  vmdiv_pkg::dstate_t din,
  output vmdiv_pkg::dstate_t dout
);
  import vmdiv_pkg::*;
  logic [32:0] r;
  logic [31:0] q;
  always_comb begin
    dout = din;
    r = {1'b0, din.rem};
    q = din.quo;
    for (int i = 0; i < BitsPerStage; i++) begin
      r = {r[31:0], q[31]};
      q = {q[30:0], 1'b0};
      if (r >= {1'b0, din.dvs}) begin
        r = r - {1'b0, din.dvs};
        q[0] = 1'b1;
      end
    end
    dout.rem = r[31:0];
    dout.quo = q;
  end
endmodule

// File: hw/rtl/vm_signed_divide_shift_alu.sv
// Top level of the VM integer ALU: division, remainder, shifts, sign extension.
`timescale 1ns / 1ps
// Fully pipelined (entry register, eight divider stages of four quotient bits
// each, sign-fix output register), one item per cycle unless stalled. All
// operations share the pipe so results leave in order. A stall at the output
// holds the whole pipe; a zero divisor gives result 0 with divide_error set.
module vm_signed_divide_shift_alu (
  input logic clk,
  input logic rst,
  vmdiv_if.sink   in_ch,
  vmdiv_if.source out_ch
);
  import vmdiv_pkg::*;
  localparam int unsigned Depth = DivStages + 1;

  dstate_t    stage [Depth];
  logic       vld [Depth];
  dstate_t    nxt [Depth];
  rsp_t       out_data;
  logic       out_vld;
  logic       adv;
  logic [31:0] fin;

  assign adv = !out_vld || out_ch.ready;
  assign in_ch.ready = adv;

  vmdiv_front u_front (.req(in_ch.data), .st(nxt[0]));
  for (genvar g = 1; g < Depth; g++) begin : g_div
    vmdiv_div_step u_step (.din(stage[g-1]), .dout(nxt[g]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
      for (int i = 0; i < Depth; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_ch.valid;
      for (int i = 1; i < Depth; i++) vld[i] <= vld[i-1];
      out_vld <= vld[Depth-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < Depth; i++) stage[i] <= nxt[i];
      out_data.result       <= fin;
      out_data.divide_error <= stage[Depth-1].dz;
    end
  end

  always_comb begin
    if (!stage[Depth-1].is_div || stage[Depth-1].dz) begin
      fin = stage[Depth-1].other;
    end else if (stage[Depth-1].is_mod) begin
      fin = stage[Depth-1].neg_r ? 32'(-stage[Depth-1].rem) : stage[Depth-1].rem;
    end else begin
      fin = stage[Depth-1].neg_q ? 32'(-stage[Depth-1].quo) : stage[Depth-1].quo;
    end
  end

  assign out_ch.valid = out_vld;
  assign out_ch.data  = out_data;
endmodule

// File: verif/tb_top.sv
// Testbench for the VM integer ALU: random and directed transfers checked against a predictor.
`timescale 1ns / 1ps
module tb_top;
  import vmdiv_pkg::*;

  class alu_scoreboard;
    rsp_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function rsp_t compute(req_t r);
      rsp_t o;
      logic [31:0] a, b, ma, mb, q;
      logic bad;
      a = r.operand_a;
      b = r.operand_b;
      o.result = '0;
      o.divide_error = 1'b0;
      bad = b[31] || (b >= 32);
      case (op_t'(r.mode))
        OP_DIV, OP_MOD: begin
          if (b == 0) begin
            o.divide_error = 1'b1;
          end else begin
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            if (op_t'(r.mode) == OP_DIV) begin
              q = ma / mb;
              o.result = (a[31] ^ b[31]) ? -q : q;
            end else begin
              q = ma % mb;
              o.result = a[31] ? -q : q;
            end
          end
        end
        OP_SHL: o.result = bad ? '0 : a << b[4:0];
        OP_SHRL: o.result = bad ? '0 : a >> b[4:0];
        OP_SHRA: o.result = bad ? {32{a[31]}} : $unsigned($signed(a) >>> b[4:0]);
        OP_SEXS: o.result = {{16{a[15]}}, a[15:0]};
        OP_SEXB: o.result = {{24{a[7]}}, a[7:0]};
        default: o.result = '0;
      endcase
      return o;
    endfunction

    function void note_request(req_t r);
      pending.push_back(compute(r));
    endfunction

    function void check_response(rsp_t got);
      rsp_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result %h", got.result);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.result !== exp.result) begin
        $error("result exp %h got %h", exp.result, got.result);
        errors++;
      end
      if (got.divide_error !== exp.divide_error) begin
        $error("divide_error exp %b got %b", exp.divide_error, got.divide_error);
        errors++;
      end
    endfunction
  endclass

  localparam int WatchdogLimit = 20000;

  logic clk = 0;
  logic rst = 1;
  int send_idle = 14;
  int recv_idle = 57;
  int stall_cycles = 0;
  alu_scoreboard sb = new();

  vmdiv_if #(.payload_t(req_t)) in_ch (clk);
  vmdiv_if #(.payload_t(rsp_t)) out_ch (clk);

  vm_signed_divide_shift_alu i_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
      if (in_ch.valid && in_ch.ready) sb.note_request(in_ch.data);
      if (out_ch.valid && out_ch.ready) sb.check_response(out_ch.data);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles > WatchdogLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send(op_t op, logic [31:0] a, logic [31:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data <= '{mode: op, operand_a: a, operand_b: b};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'hFFFF_FFFF;
      2: return '0;
      3: return $urandom_range(40);
      4: return -$urandom_range(40);
      5: return $urandom_range(65535);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(int n);
    logic [2:0] m;
    repeat (n) begin
      m = 3'($urandom_range(7));
      send(op_t'(m), pick_word(), pick_word());
    end
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send(OP_DIV, 32'd100, 32'd7);
    send(OP_DIV, -32'sd100, 32'd7);
    send(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
    send(OP_DIV, 32'd5, 32'd0);
    send(OP_DIV, 32'hFFFF_FFFF, 32'h8000_0000);
    send(OP_MOD, -32'sd100, 32'd7);
    send(OP_MOD, 32'h8000_0000, 32'hFFFF_FFFF);
    send(OP_MOD, 32'd9, 32'd0);
    send(OP_SHL, 32'hFFFF_FFFF, 32'd31);
    send(OP_SHL, 32'h1, 32'd32);
    send(OP_SHL, 32'h1, 32'hFFFF_FFFF);
    send(OP_SHRL, 32'h8000_0000, 32'd31);
    send(OP_SHRL, 32'hFFFF_FFFF, 32'd0);
    send(OP_SHRL, 32'hFFFF_FFFF, 32'h8000_0000);
    send(OP_SHRA, 32'h8000_0000, 32'd31);
    send(OP_SHRA, 32'h8000_0000, 32'd40);
    send(OP_SHRA, 32'h7FFF_FFFF, 32'hFFFF_FFFE);
    send(OP_SEXS, 32'h1234_8000, 32'hFFFF_FFFF);
    send(OP_SEXS, 32'hFFFF_7FFF, 32'd0);
    send(OP_SEXB, 32'h0000_0080, 32'd0);
    send(OP_SEXB, 32'hFFFF_FF7F, 32'd0);
    send(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_phase(480);
    send_idle = 57;
    recv_idle = 14;
    random_phase(480);
    send_idle = 0;
    recv_idle = 0;
    random_phase(490);
    in_ch.valid <= 0;
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// File: vm_signed_divide_shift_alu.f
hw/rtl/vmdiv_pkg.sv
hw/rtl/vmdiv_if.sv
hw/rtl/vmdiv_front.sv
hw/rtl/vmdiv_div_step.sv
hw/rtl/vm_signed_divide_shift_alu.sv
verif/tb_top.sv
